// ----- sv/tab_text_to_html_table_tokens_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the tab text to HTML table token converter
// Shared same-cycle implication and next-cycle property forms, clocked on clk
// and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TAB_TEXT_TO_HTML_TABLE_TOKENS_DEFINES_SVH
`define TAB_TEXT_TO_HTML_TABLE_TOKENS_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define TTH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define TTH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tthtml_pkg.sv -----
// ----------------------------------------------------------------------------
// tthtml_pkg
// Token codes, character codes and the run type shared by the converter.
// ----------------------------------------------------------------------------
package tthtml_pkg;

    localparam int unsigned CHAR_BITS_DEFAULT = 16;

    // Most tokens one item can cause, and the width of a token count
    localparam int unsigned RUN_MAX  = 5;
    localparam int unsigned CNT_BITS = $clog2(RUN_MAX + 1);

    // Character codes that steer the conversion
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_LT  = 8'h3C;
    localparam logic [7:0] CODE_GT  = 8'h3E;
    localparam logic [7:0] CODE_AMP = 8'h26;

    typedef enum logic [3:0] {
        TK_LIT         = 4'd0,
        TK_TABLE_OPEN  = 4'd1,
        TK_TABLE_CLOSE = 4'd2,
        TK_ROW_OPEN    = 4'd3,
        TK_ROW_CLOSE   = 4'd4,
        TK_TH_OPEN     = 4'd5,
        TK_TH_CLOSE    = 4'd6,
        TK_TD_OPEN     = 4'd7,
        TK_TD_CLOSE    = 4'd8,
        TK_LT          = 4'd9,
        TK_GT          = 4'd10,
        TK_AMP         = 4'd11,
        TK_END         = 4'd12
    } tok_kind_t;

    // Tokens caused by one item, in emission order
    typedef struct packed {
        tok_kind_t [RUN_MAX-1:0] kind;
        logic [CNT_BITS-1:0]     count;
    } run_t;

endpackage

// ----- sv/tthtml_if.sv -----
// ----------------------------------------------------------------------------
// tthtml channel interfaces
// Text character channel and token channel, both valid/ready.
// ----------------------------------------------------------------------------
interface tthtml_in_if
    import tthtml_pkg::*;
#(
    parameter int unsigned CHAR_BITS = CHAR_BITS_DEFAULT
);
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [CHAR_BITS-1:0] char_code;

    modport source (output valid, output op, output char_code, input ready);
    modport sink   (input valid, input op, input char_code, output ready);
endinterface

interface tthtml_out_if
    import tthtml_pkg::*;
#(
    parameter int unsigned CHAR_BITS = CHAR_BITS_DEFAULT
);
    logic                 valid;
    logic                 ready;
    tok_kind_t            token_kind;
    logic [CHAR_BITS-1:0] literal_code;
    logic                 last_of_run;

    modport source (output valid, output token_kind, output literal_code,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input literal_code,
                    input last_of_run, output ready);
endinterface

// ----- sv/tthtml_decode.sv -----
// ----------------------------------------------------------------------------
// tthtml_decode
// Holds the table/row/cell state and builds the token run for one item.
// ----------------------------------------------------------------------------
module tthtml_decode
    import tthtml_pkg::*;
#(
    parameter int unsigned CHAR_BITS = CHAR_BITS_DEFAULT
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 op,
    input  logic [CHAR_BITS-1:0] char_code,
    output run_t                 run
);

    typedef enum logic [3:0] {
        PH_SKIP  = 4'b0001,
        PH_HEAD  = 4'b0010,
        PH_AFTER = 4'b0100,
        PH_DATA  = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        SW_NONE = 2'd0,
        SW_LF   = 2'd1,
        SW_CR   = 2'd2
    } swallow_t;

    phase_t   phase_reg, phase_next;
    swallow_t sw_reg, sw_next;
    logic     cell_reg, cell_next;
    logic     row_reg, row_next;

    logic is_cr, is_lf, brk, pair_hit;

    // Append one token to a run
    function automatic run_t add_tok(run_t r, tok_kind_t k);
        run_t o;
        o = r;
        if (r.count < CNT_BITS'(RUN_MAX))
        begin
            o.kind[r.count] = k;
            o.count         = r.count + CNT_BITS'(1);
        end
        return o;
    endfunction

    // Append the tokens of a character inside an open cell
    function automatic run_t add_body(run_t r, logic [CHAR_BITS-1:0] c, logic hdr);
        run_t o;
        o = r;
        if (c == CHAR_BITS'(CODE_TAB))
        begin
            o = add_tok(o, hdr ? TK_TH_CLOSE : TK_TD_CLOSE);
            o = add_tok(o, hdr ? TK_TH_OPEN : TK_TD_OPEN);
        end
        else if (c == CHAR_BITS'(CODE_LT))
            o = add_tok(o, TK_LT);
        else if (c == CHAR_BITS'(CODE_GT))
            o = add_tok(o, TK_GT);
        else if (c == CHAR_BITS'(CODE_AMP))
            o = add_tok(o, TK_AMP);
        else
            o = add_tok(o, TK_LIT);
        return o;
    endfunction

    assign is_cr    = (char_code == CHAR_BITS'(CODE_CR));
    assign is_lf    = (char_code == CHAR_BITS'(CODE_LF));
    assign brk      = is_cr || is_lf;
    assign pair_hit = ((sw_reg == SW_LF) && is_lf) || ((sw_reg == SW_CR) && is_cr);

    // Build the run and the next state
    always_comb
    begin
        run_t r;
        logic row_v;
        logic cell_v;
        r          = '0;
        row_v      = row_reg;
        cell_v     = cell_reg;
        phase_next = phase_reg;
        sw_next    = sw_reg;
        cell_next  = cell_reg;
        row_next   = row_reg;
        if (op)
        begin
            // End of text: close what is open, then terminate
            if (phase_reg != PH_SKIP)
            begin
                if (cell_reg)
                    r = add_tok(r, (phase_reg == PH_HEAD) ? TK_TH_CLOSE : TK_TD_CLOSE);
                if (row_reg)
                    r = add_tok(r, TK_ROW_CLOSE);
                r = add_tok(r, TK_TABLE_CLOSE);
            end
            r          = add_tok(r, TK_END);
            phase_next = PH_SKIP;
            sw_next    = SW_NONE;
            cell_next  = 1'b0;
            row_next   = 1'b0;
        end
        else
        begin
            sw_next = SW_NONE;
            if (!pair_hit)
            begin
                case (phase_reg)
                    PH_SKIP:
                    begin
                        if (!brk)
                        begin
                            r          = add_tok(r, TK_TABLE_OPEN);
                            r          = add_tok(r, TK_ROW_OPEN);
                            r          = add_tok(r, TK_TH_OPEN);
                            r          = add_body(r, char_code, 1'b1);
                            row_next   = 1'b1;
                            cell_next  = 1'b1;
                            phase_next = PH_HEAD;
                        end
                    end
                    PH_HEAD:
                    begin
                        if (brk)
                        begin
                            r          = add_tok(r, TK_TH_CLOSE);
                            r          = add_tok(r, TK_ROW_CLOSE);
                            cell_next  = 1'b0;
                            row_next   = 1'b0;
                            sw_next    = is_cr ? SW_LF : SW_CR;
                            phase_next = PH_AFTER;
                        end
                        else
                            r = add_body(r, char_code, 1'b1);
                    end
                    PH_AFTER, PH_DATA:
                    begin
                        // First data line always opens a row
                        if (phase_reg == PH_AFTER)
                        begin
                            r          = add_tok(r, TK_ROW_OPEN);
                            r          = add_tok(r, TK_TD_OPEN);
                            row_v      = 1'b1;
                            cell_v     = 1'b1;
                            phase_next = PH_DATA;
                        end
                        if (brk)
                        begin
                            if (cell_v)
                                r = add_tok(r, TK_TD_CLOSE);
                            if (row_v)
                                r = add_tok(r, TK_ROW_CLOSE);
                            cell_next = 1'b0;
                            row_next  = 1'b0;
                            sw_next   = is_cr ? SW_LF : SW_CR;
                        end
                        else
                        begin
                            if (!row_v)
                                r = add_tok(r, TK_ROW_OPEN);
                            if (!cell_v)
                                r = add_tok(r, TK_TD_OPEN);
                            r         = add_body(r, char_code, 1'b0);
                            row_next  = 1'b1;
                            cell_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_SKIP;
                    end
                endcase
            end
        end
        run = r;
    end

    // Advance the state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            sw_reg    <= SW_NONE;
            cell_reg  <= 1'b0;
            row_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            sw_reg    <= sw_next;
            cell_reg  <= cell_next;
            row_reg   <= row_next;
        end
    end

endmodule

// ----- sv/tthtml_serial.sv -----
// ----------------------------------------------------------------------------
// tthtml_serial
// Holds one token run and hands its tokens out one per cycle while token_out is ready.
// ----------------------------------------------------------------------------
`include "tab_text_to_html_table_tokens_defines.svh"

module tthtml_serial
    import tthtml_pkg::*;
#(
    parameter int unsigned CHAR_BITS = CHAR_BITS_DEFAULT
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  run_t                 run,
    input  logic [CHAR_BITS-1:0] lit,
    output logic                 take_ready,
    tthtml_out_if.source         token_out
);

    run_t                 run_reg;
    logic [CHAR_BITS-1:0] lit_reg;
    logic [CNT_BITS-1:0]  idx_reg;
    logic                 full_reg;

    logic      last_tok;
    logic      out_fire;
    tok_kind_t kind_cur;

    assign kind_cur   = run_reg.kind[idx_reg];
    assign last_tok   = (idx_reg == run_reg.count - CNT_BITS'(1));
    assign out_fire   = full_reg && token_out.ready;
    assign take_ready = !full_reg || (out_fire && last_tok);

    // Drive the token channel
    assign token_out.valid        = full_reg;
    assign token_out.token_kind   = kind_cur;
    assign token_out.literal_code = (kind_cur == TK_LIT) ? lit_reg : '0;
    assign token_out.last_of_run  = last_tok;

    // Hold the payload of a new run
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            run_reg <= run;
            lit_reg <= lit;
        end
    end

    // Load a run or advance through it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            full_reg <= (run.count != '0);
            idx_reg  <= '0;
        end
        else if (out_fire)
        begin
            if (last_tok)
                full_reg <= 1'b0;
            else
                idx_reg <= idx_reg + CNT_BITS'(1);
        end
    end

    `TTH_ASSERT_NOW(a_count_range, full_reg,
        (run_reg.count != '0) && (run_reg.count <= CNT_BITS'(RUN_MAX)),
        "run count out of range")
    `TTH_ASSERT_NOW(a_idx_in_run, full_reg, idx_reg < run_reg.count,
        "token index past end of run")
    `TTH_ASSERT_NOW(a_no_overwrite, load && full_reg, out_fire && last_tok,
        "run overwritten before it was delivered")
    `TTH_ASSERT_NEXT(a_idx_step, out_fire && !last_tok && !load,
        full_reg && (idx_reg == $past(idx_reg) + CNT_BITS'(1)),
        "token index did not advance")

endmodule

// ----- sv/tab_text_to_html_table_tokens.sv -----
// ----------------------------------------------------------------------------
// tab_text_to_html_table_tokens
// Converts tab-separated text characters into HTML table tokens.
//
//   channel    dir  handshake     payload
//   text_in    in   valid/ready   op, char_code
//   token_out  out  valid/ready   token_kind, literal_code, last_of_run
//
// An item is decoded in the cycle it is accepted and its run of 0 to 5 tokens
// is loaded into the single token output register; tokens leave token_out one
// per cycle while token_out is ready, starting the next cycle.
// A new item is taken in the cycle the last token of the previous run is taken,
// or when no run is held, so a stall on token_out holds text_in.ready low.
// Reset clears the decode state and empties the token output register.
// ----------------------------------------------------------------------------
module tab_text_to_html_table_tokens
    import tthtml_pkg::*;
#(
    parameter int unsigned CHAR_BITS = CHAR_BITS_DEFAULT
)(
    input  logic         clk,
    input  logic         rst_n,
    tthtml_in_if.sink    text_in,
    tthtml_out_if.source token_out
);

    logic accept;
    logic take_ready;
    run_t run;

    assign text_in.ready = take_ready;
    assign accept        = text_in.valid && take_ready;

    // Decode state and token run
    tthtml_decode #(
        .CHAR_BITS (CHAR_BITS)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (text_in.op),
        .char_code (text_in.char_code),
        .run       (run)
    );

    // Token run register and output
    tthtml_serial #(
        .CHAR_BITS (CHAR_BITS)
    ) u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .run        (run),
        .lit        (text_in.char_code),
        .take_ready (take_ready),
        .token_out  (token_out)
    );

endmodule
